/* hdl/sqtg_pkg.sv */
// ----------------------------------------------------------------------------
// sqtg_pkg
// Shared types, constants and the volume level table of the square tone
// generator.
// ----------------------------------------------------------------------------
package sqtg_pkg;

	localparam int RATE_W    = 24;
	localparam int SCALE_W   = 10;
	localparam int PERIOD_W  = 12;
	localparam int VOL_W     = 4;
	localparam int LEVEL_W   = 13;
	localparam int SAMPLE_W  = 16;
	localparam int SEL_W     = 4;
	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = 5;

	localparam int FREQ_SHIFT_DEF = 4;
	localparam int CHANNELS_DEF   = 3;

	localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(650);
	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(16);

	localparam logic [OP_W-1:0] OP_SELECT = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd2;

	localparam logic [SEL_W-1:0] REG_TONE_DIS = 4'd7;
	localparam int               REG_VOL_BASE = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CH_LOAD,
		ST_CMP,
		ST_DIV1,
		ST_POST,
		ST_MUL,
		ST_DIV2,
		ST_ACC,
		ST_NEXT,
		ST_OUT
	} state_t;

	function automatic logic [LEVEL_W-1:0] level_of(input logic [VOL_W-1:0] idx);
		logic [LEVEL_W-1:0] lv;
		case (idx)
			4'd0:    lv = 13'd46;
			4'd1:    lv = 13'd65;
			4'd2:    lv = 13'd92;
			4'd3:    lv = 13'd130;
			4'd4:    lv = 13'd183;
			4'd5:    lv = 13'd259;
			4'd6:    lv = 13'd366;
			4'd7:    lv = 13'd517;
			4'd8:    lv = 13'd730;
			4'd9:    lv = 13'd1031;
			4'd10:   lv = 13'd1457;
			4'd11:   lv = 13'd2057;
			4'd12:   lv = 13'd2906;
			4'd13:   lv = 13'd4105;
			4'd14:   lv = 13'd5799;
			default: lv = 13'd8191;
		endcase
		return lv;
	endfunction

endpackage

/* hdl/three_channel_square_tone_generator.sv */
// ----------------------------------------------------------------------------
// three_channel_square_tone_generator
// Three square tone channels behind a select/data register pair; a sample
// request averages each channel over one sample interval and sums them.
// ----------------------------------------------------------------------------
// Select and write transfers complete when accepted. A sample runs ST_CHECK,
// then per channel ST_CH_LOAD, ST_CMP if it is active and, on a half-period
// crossing, the shared restoring divider (one quotient bit a cycle: 24 steps
// for the crossing count, 13 for the rounded average), ST_NEXT; last ST_OUT.
// Input is not ready while a sample is in work. arst_n clears the tone
// registers, timers and phases; rate 650, scale 16, sound enabled.
module three_channel_square_tone_generator #(
	parameter int FREQ_SHIFT = sqtg_pkg::FREQ_SHIFT_DEF,
	parameter int CHANNELS   = sqtg_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sqtg_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data
	input  logic [sqtg_pkg::OP_W-1:0]         s_tuser,   // [1:0] opcode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sqtg_pkg::SAMPLE_W-1:0]     m_tdata,   // [15:0] sample
	input  logic                              cfg_we,
	input  logic [sqtg_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [sqtg_pkg::RATE_W-1:0]       cfg_wdata
);
	import sqtg_pkg::*;

	localparam int HW     = 13 + FREQ_SHIFT + SCALE_W;
	localparam int P1_W   = 13 + FREQ_SHIFT;
	localparam int DW     = ((HW > RATE_W) ? HW : RATE_W) + 1;
	localparam int SW     = DW + 2;
	localparam int PROD_W = LEVEL_W + RATE_W;
	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t state_q, state_d;

	logic [RATE_W-1:0]   rate_q;
	logic [SCALE_W-1:0]  scale_q;
	logic                en_q;
	logic [SEL_W-1:0]    sel_q;
	logic [PERIOD_W-1:0] period_q [CHANNELS];
	logic                on_q     [CHANNELS];
	logic [VOL_W-1:0]    vol_q    [CHANNELS];
	logic [HW-1:0]       timer_q  [CHANNELS];
	logic                phase_q  [CHANNELS];

	logic [CW-1:0]       ch_q;
	logic [HW-1:0]       half_q;
	logic [HW-1:0]       t_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       dvs_q;
	logic [RATE_W-1:0]   dq_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RATE_W-1:0]   mag_q;
	logic                neg_q;
	logic signed [SAMPLE_W-1:0] acc_q;
	logic [SAMPLE_W-1:0] out_q;
	logic                mvalid_q;

	logic                in_xfer;
	logic                out_load;
	logic                any_act;
	logic [CHANNELS-1:0] act;
	logic [RATE_W-1:0]   rate_eff;
	logic [SCALE_W-1:0]  scale_eff;
	logic [P1_W-1:0]     p1_sh;
	logic [HW-1:0]       half_d;
	logic [LEVEL_W-1:0]  level;
	logic                ge_rate;
	logic [DW-1:0]       shifted;
	logic [DW:0]         trial;
	logic                qbit;
	logic [DW-1:0]       last;
	logic signed [SW-1:0] inner;
	logic signed [SW-1:0] inner_abs;
	logic                sum_neg;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] amp;

	assign in_xfer   = s_tvalid && s_tready;
	assign rate_eff  = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign scale_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			act[i] = on_q[i] && (period_q[i] != '0);
		end
	end
	assign any_act = |act;

	// per-channel operands
	assign p1_sh   = P1_W'(period_q[ch_q] + PERIOD_W'(0) + 13'd1) << FREQ_SHIFT;
	assign half_d  = HW'(p1_sh) * HW'(scale_eff);
	assign level   = level_of(vol_q[ch_q]);
	assign ge_rate = DW'(t_q) >= DW'(rate_eff);

	// shared restoring divide step
	assign shifted = {rem_q[DW-2:0], dq_q[RATE_W-1]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};
	assign qbit    = !trial[DW];

	// crossing result: rem = (dist-1) mod half, dq_q[0] = parity of (dist-1)/half
	assign last = rem_q + DW'(1);
	always_comb begin
		if (dq_q[0]) begin
			inner = $signed(SW'(t_q)) + $signed(SW'(last)) - $signed(SW'(half_q));
		end else begin
			inner = $signed(SW'(t_q)) - $signed(SW'(last));
		end
		inner_abs = (inner < 0) ? -inner : inner;
		sum_neg   = phase_q[ch_q] ? (inner < 0) : (inner > 0);
	end

	assign prod = PROD_W'(level) * PROD_W'(mag_q) + PROD_W'(rate_eff >> 1);
	assign amp  = SAMPLE_W'(dq_q[LEVEL_W-1:0]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && s_tuser == OP_SAMPLE) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = (en_q && any_act) ? ST_CH_LOAD : ST_OUT;
			end
			ST_CH_LOAD: begin
				state_d = act[ch_q] ? ST_CMP : ST_NEXT;
			end
			ST_CMP: begin
				state_d = ge_rate ? ST_NEXT : ST_DIV1;
			end
			ST_DIV1: begin
				if (cnt_q == CNT_W'(1)) state_d = ST_POST;
			end
			ST_POST: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_DIV2;
			end
			ST_DIV2: begin
				if (cnt_q == CNT_W'(1)) state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				state_d = (ch_q == CW'(CHANNELS - 1)) ? ST_OUT : ST_CH_LOAD;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		out_load = (state_q == ST_OUT) && (!mvalid_q || m_tready);
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (out_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= acc_q;
		end
	end

	// register file and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= RATE_RST;
			scale_q <= SCALE_RST;
			en_q    <= 1'b1;
			sel_q   <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				period_q[i] <= '0;
				on_q[i]     <= 1'b0;
				vol_q[i]    <= '0;
				timer_q[i]  <= '0;
				phase_q[i]  <= 1'b0;
			end
		end else begin
			if (in_xfer && s_tuser == OP_SELECT) begin
				sel_q <= s_tdata[SEL_W-1:0];
			end
			if (in_xfer && s_tuser == OP_WRITE) begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (sel_q == SEL_W'(2 * i)) period_q[i][7:0] <= s_tdata;
					if (sel_q == SEL_W'(2 * i + 1)) period_q[i][11:8] <= s_tdata[3:0];
					if (sel_q == REG_TONE_DIS) on_q[i] <= !s_tdata[i];
					if (sel_q == SEL_W'(REG_VOL_BASE + i)) vol_q[i] <= s_tdata[VOL_W-1:0];
				end
			end
			if (state_q == ST_CMP && ge_rate) begin
				timer_q[ch_q] <= t_q - HW'(rate_eff);
			end
			if (state_q == ST_POST) begin
				timer_q[ch_q] <= half_q - HW'(last);
				phase_q[ch_q] <= phase_q[ch_q] ^ !dq_q[0];
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_RATE:   rate_q  <= cfg_wdata;
					CFG_SCALE:  scale_q <= cfg_wdata[SCALE_W-1:0];
					CFG_ENABLE: en_q    <= cfg_wdata[0];
					default: ;
				endcase
				if (cfg_addr == CFG_RATE || cfg_addr == CFG_SCALE) begin
					for (int i = 0; i < CHANNELS; i++) begin
						timer_q[i] <= '0;
						phase_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	// sequencer working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CHECK: ch_q <= '0;
				ST_CMP:   cnt_q <= CNT_W'(RATE_W);
				ST_MUL:   cnt_q <= CNT_W'(LEVEL_W);
				ST_DIV1,
				ST_DIV2:  cnt_q <= cnt_q - CNT_W'(1);
				ST_NEXT: begin
					if (ch_q != CW'(CHANNELS - 1)) ch_q <= ch_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				acc_q <= '0;
			end
			ST_CH_LOAD: begin
				half_q <= half_d;
				t_q    <= timer_q[ch_q];
			end
			ST_CMP: begin
				if (ge_rate) begin
					acc_q <= phase_q[ch_q] ? acc_q + $signed(SAMPLE_W'(level))
					                       : acc_q - $signed(SAMPLE_W'(level));
				end
				rem_q <= '0;
				dvs_q <= DW'(half_q);
				dq_q  <= rate_eff - RATE_W'(t_q) - RATE_W'(1);
			end
			ST_DIV1,
			ST_DIV2: begin
				rem_q <= qbit ? trial[DW-1:0] : shifted;
				dq_q  <= {dq_q[RATE_W-2:0], qbit};
			end
			ST_POST: begin
				mag_q <= inner_abs[RATE_W-1:0];
				neg_q <= sum_neg;
			end
			ST_MUL: begin
				rem_q <= DW'(prod[PROD_W-1:LEVEL_W]);
				dq_q  <= {prod[LEVEL_W-1:0], (RATE_W - LEVEL_W)'(0)};
				dvs_q <= DW'(rate_eff);
			end
			ST_ACC: begin
				acc_q <= neg_q ? acc_q - $signed(amp) : acc_q + $signed(amp);
			end
			default: ;
		endcase
	end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the three channel square tone generator. Streams register
// select, register write and sample request transfers into the block. A
// scoreboard keeps its own copy of the tone registers, phase timers and rate
// settings and predicts every sample word. Results are compared in order.
// Gaps on both sides are random. Rate, scale and enable are changed between
// phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sqtg_pkg::*;

	localparam logic [OP_W-1:0]      OP_NONE         = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE        = 2'd3;
	localparam logic [SEL_W-1:0]     REG_PERIOD_BASE = 4'd0;
	localparam logic [SEL_W-1:0]     REG_PERIOD_LAST = 4'd5;
	localparam logic [SEL_W-1:0]     REG_UNUSED      = 4'd6;
	localparam logic [SEL_W-1:0]     REG_TOP         = 4'd15;
	localparam int SETTLE_CYCLES = 160;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 90;

	class tone_scoreboard;
		logic [RATE_W-1:0]   rate;
		logic [SCALE_W-1:0]  scale;
		logic                enable;
		logic [SEL_W-1:0]    sel;
		logic [PERIOD_W-1:0] period [CHANNELS_DEF];
		logic                tone_on [CHANNELS_DEF];
		logic [VOL_W-1:0]    vol [CHANNELS_DEF];
		logic [31:0]         timer [CHANNELS_DEF];
		logic                phase [CHANNELS_DEF];
		logic [SAMPLE_W-1:0] due_samples [$];
		int unsigned volume_levels [16] = '{46, 65, 92, 130, 183, 259, 366, 517,
			730, 1031, 1457, 2057, 2906, 4105, 5799, 8191};
		int errors;
		int checked;

		function new();
			rate = RATE_RST;
			scale = SCALE_RST;
			enable = 1'b1;
			sel = '0;
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				period[c] = '0;
				tone_on[c] = 1'b0;
				vol[c] = '0;
			end
			clear_phases();
			errors = 0;
			checked = 0;
		endfunction

		function void clear_phases();
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				timer[c] = '0;
				phase[c] = 1'b0;
			end
		endfunction

		function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
			case (idx)
				CFG_RATE: begin
					rate = val;
					clear_phases();
				end
				CFG_SCALE: begin
					scale = val[SCALE_W-1:0];
					clear_phases();
				end
				CFG_ENABLE: enable = val[0];
				default: ;
			endcase
		endfunction

		function bit active(int c);
			return tone_on[c] && period[c] != '0;
		endfunction

		// area-weighted average of one channel over one sample interval
		function longint channel_average(int c, longint unsigned r);
			longint unsigned half, lvl, t, span, n, last, mag, amp;
			longint inner, acc;
			if (!active(c))
				return 0;
			half = (64'(period[c]) + 1) << FREQ_SHIFT_DEF;
			half = half * (scale == '0 ? 64'd1 : 64'(scale));
			lvl = volume_levels[vol[c]];
			t = 64'(timer[c]);
			if (t >= r) begin
				timer[c] = 32'(t - r);
				return phase[c] ? longint'(lvl) : -longint'(lvl);
			end
			span = r - t;
			n = (span + half - 1) / half;
			last = span - (n - 1) * half;
			inner = longint'(t);
			if (n[0] == 1'b0)
				inner = inner + longint'(last) - longint'(half);
			else
				inner = inner - longint'(last);
			acc = phase[c] ? inner : -inner;
			timer[c] = 32'(n * half - span);
			phase[c] = phase[c] ^ n[0];
			mag = (acc < 0) ? -acc : acc;
			amp = (lvl * mag + r / 2) / r;
			return (acc < 0) ? -longint'(amp) : longint'(amp);
		endfunction

		function void write_tone(logic [BYTE_W-1:0] d);
			int c;
			if (sel <= REG_PERIOD_LAST) begin
				c = int'(sel >> 1);
				if (c < CHANNELS_DEF) begin
					if (!sel[0])
						period[c][7:0] = d;
					else
						period[c][11:8] = d[3:0];
				end
			end else if (sel == REG_TONE_DIS) begin
				for (c = 0; c < CHANNELS_DEF; c++)
					tone_on[c] = ~d[c];
			end else if (sel >= REG_VOL_BASE && sel < REG_VOL_BASE + CHANNELS_DEF) begin
				vol[sel - REG_VOL_BASE] = d[VOL_W-1:0];
			end
		endfunction

		function void note_transfer(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d);
			bit any;
			longint unsigned r;
			longint total;
			case (op)
				OP_SELECT: sel = d[SEL_W-1:0];
				OP_WRITE:  write_tone(d);
				OP_SAMPLE: begin
					any = 1'b0;
					total = 0;
					for (int c = 0; c < CHANNELS_DEF; c++)
						if (active(c))
							any = 1'b1;
					if (enable && any) begin
						r = (rate == '0) ? 64'd1 : 64'(rate);
						for (int c = 0; c < CHANNELS_DEF; c++)
							total += channel_average(c, r);
					end
					due_samples.push_back(SAMPLE_W'(total));
				end
				default: ;
			endcase
		endfunction

		function void check_sample(logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			if (due_samples.size() == 0) begin
				errors++;
				$display("%0t: unexpected sample, expected none, actual %0d",
					$time, $signed(got));
				return;
			end
			want = due_samples.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$display("%0t: sample mismatch, expected %0d, actual %0d",
					$time, $signed(want), $signed(got));
			end
		endfunction

		function int pending();
			return due_samples.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata;
	logic [OP_W-1:0]      s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [SAMPLE_W-1:0]  m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [RATE_W-1:0]    cfg_wdata;

	tone_scoreboard sb = new();
	bit hold_req;
	bit src_steady;
	bit sink_steady;

	three_channel_square_tone_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_sample(m_tdata);
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 150);
	endfunction

	task automatic idle(int n);
		s_tvalid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d);
		s_tuser = op;
		s_tdata = d;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_transfer(op, d);
		@(negedge clk);
	endtask

	task automatic issue(logic [OP_W-1:0] op, logic [BYTE_W-1:0] d);
		if (!src_steady && $urandom_range(0, 3) == 0)
			idle(gap_len());
		send_item(op, d);
	endtask

	task automatic write_tone_reg(logic [SEL_W-1:0] r, logic [BYTE_W-1:0] d);
		issue(OP_SELECT, {4'($urandom), r});
		issue(OP_WRITE, d);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		sb.write_cfg(idx, val);
		@(negedge clk);
	endtask

	function automatic logic [SEL_W-1:0] pick_reg();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return REG_PERIOD_BASE + SEL_W'($urandom_range(0, 5));
		else if (r < 75)
			return REG_TONE_DIS;
		else if (r < 95)
			return SEL_W'(REG_VOL_BASE + $urandom_range(0, CHANNELS_DEF - 1));
		else if (r < 97)
			return REG_UNUSED;
		return SEL_W'($urandom_range(REG_VOL_BASE + CHANNELS_DEF, REG_TOP));
	endfunction

	// register program with random content followed by a run of samples,
	// or a single stray transfer
	task automatic random_burst(inout int count);
		int k;
		logic [SEL_W-1:0] r;
		logic [BYTE_W-1:0] d;
		if ($urandom_range(0, 9) < 7) begin
			k = $urandom_range(1, 3);
			repeat (k) begin
				r = pick_reg();
				d = 8'($urandom);
				if (r <= REG_PERIOD_LAST && r[0] && $urandom_range(0, 1))
					d[3:0] = 4'd0;
				write_tone_reg(r, d);
				count += 2;
			end
			k = $urandom_range(1, 12);
			repeat (k) begin
				issue(OP_SAMPLE, 8'($urandom));
				count++;
			end
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					issue(OP_SELECT, 8'($urandom));
					count++;
				end
				1: begin
					issue(OP_WRITE, 8'($urandom));
					count++;
				end
				2: issue(OP_NONE, 8'($urandom));
				default: begin
					issue(OP_SAMPLE, 8'($urandom));
					count++;
				end
			endcase
		end
	endtask

	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				m_tready = 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int count;
		logic [RATE_W-1:0] r;
		logic [SCALE_W-1:0] s;
		logic en;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_SELECT;
		cfg_we = 1'b0;
		cfg_addr = CFG_RATE;
		cfg_wdata = '0;
		hold_req = 1'b0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, silent start, period and volume extremes,
		// zero period on an enabled channel, unused registers, unknown opcode
		issue(OP_SAMPLE, 8'hFF);
		issue(OP_NONE, 8'hFF);
		write_tone_reg(REG_TONE_DIS, 8'hF8);
		write_tone_reg(REG_PERIOD_BASE, 8'hFF);
		write_tone_reg(REG_PERIOD_BASE + 4'd1, 8'hFF);
		write_tone_reg(SEL_W'(REG_VOL_BASE), 8'h0F);
		issue(OP_SAMPLE, 8'h00);
		write_tone_reg(REG_PERIOD_BASE + 4'd2, 8'h01);
		write_tone_reg(SEL_W'(REG_VOL_BASE + 1), 8'hF0);
		issue(OP_SAMPLE, 8'h55);
		write_tone_reg(REG_PERIOD_BASE + 4'd5, 8'h01);
		write_tone_reg(REG_UNUSED, 8'hFF);
		write_tone_reg(REG_TOP, 8'hFF);
		repeat (3) issue(OP_SAMPLE, 8'($urandom));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			en = 1'b1;
			case (p)
				0: begin
					r = RATE_RST;
					s = SCALE_RST;
				end
				1: begin
					r = 24'd1;
					s = 10'd1;
				end
				2: begin
					r = 24'hFFFFFF;
					s = 10'h3FF;
				end
				3: begin
					r = '0;
					s = '0;
				end
				4: begin
					r = RATE_RST;
					s = SCALE_RST;
					en = 1'b0;
				end
				5: begin
					r = RATE_W'($urandom_range(1, 4000));
					s = SCALE_W'($urandom_range(1, 64));
				end
				6: begin
					r = 24'hFFFFFF;
					s = 10'd1;
				end
				7: begin
					r = RATE_W'($urandom);
					s = SCALE_W'($urandom);
				end
				8: begin
					r = 24'd1;
					s = 10'h3FF;
				end
				default: begin
					r = RATE_W'($urandom_range(100, 20000));
					s = SCALE_W'($urandom_range(1, 32));
				end
			endcase
			// last phase keeps the running phase timers: enable only
			if (p != PHASES - 1) begin
				cfg_write(CFG_RATE, r);
				cfg_write(CFG_SCALE, RATE_W'(s));
			end else begin
				cfg_write(CFG_NONE, RATE_W'($urandom));
			end
			cfg_write(CFG_ENABLE, RATE_W'(en));
			cfg_we = 1'b0;
			src_steady = (p % 4 == 1);
			sink_steady = (p % 3 == 2);
			count = 0;
			if (p == 7) begin
				hold_req = 1'b1;
				repeat (24) send_item(OP_SAMPLE, 8'($urandom));
				count = 24;
			end
			while (count < PHASE_ITEMS)
				random_burst(count);
		end
		settle();

		$display("%0d samples checked over %0d rate, scale and enable settings,",
			sb.checked, PHASES + 1);
		$display("including minimum and maximum rate and scale, zero values and silence");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
